// ----- design/als_pkg.sv -----
// Package for the array list store: sizes, command and status codes,
// request/response payload types and the entry memory port types.
// No dependencies.
package als_pkg;

  // List sizing
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 11;
  localparam int WORD_W   = 32;

  // Command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_SET    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // One stored entry
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } entry_t;

  // Request payload
  typedef struct packed {
    logic [2:0]        command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] coord_x;
    logic [WORD_W-1:0] coord_y;
    logic [WORD_W-1:0] coord_z;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] read_x;
    logic [WORD_W-1:0] read_y;
    logic [WORD_W-1:0] read_z;
    logic [CNT_W-1:0]  item_count;
  } rsp_t;

  // Entry memory write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  // Entry memory read port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

// ----- design/array_list_store_core.sv -----
// Top level of the array list store: command sequencer and shift engine
// around the entry memory. Depends on als_pkg and als_mem.
//
// Usage:
//   A request (req_i) is taken at a rising edge where start is high and busy
//   is low. Each request gives exactly one response on rsp_o, marked by a
//   one-cycle strobe on done_o; the receiver cannot stall it and must take it
//   in that cycle.
//   Append, set, rejected commands and remove of the last entry are done
//   from the idle state; get passes through S_GET for the memory read;
//   insert at position p with count n (p < n) steps through S_UP,
//   S_UP_LAST and S_PUT; remove at position p with count n (p < n - 1)
//   steps through S_DN and S_DN_LAST.
//   Insert and remove move one entry per cycle through the single
//   read/write port pair of the entry memory. busy is high while the
//   sequencer is in any of these states; a new request may be accepted
//   in the cycle where the previous response is strobed.
//   Reset clears the count to zero; entry contents are not cleared and are
//   only ever read after they have been written.
module array_list_store_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  als_pkg::req_t req_i,
  output logic          done_o,
  output als_pkg::rsp_t rsp_o
);
  import als_pkg::*;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP      = 3'd1;
  localparam logic [2:0] S_UP_LAST = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_DN      = 3'd4;
  localparam logic [2:0] S_DN_LAST = 3'd5;
  localparam logic [2:0] S_GET     = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              pend_q, pend_d;
  rsp_t              rsp_q, rsp_d;
  req_t              req_q, req_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] wa_q, wa_d;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  entry_t            rdata;
  entry_t            req_entry;
  logic              accept;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] lat_pos;
  logic [ADDR_W-1:0] cnt_addr;

  als_mem u_mem (
    .clk_i  (clk_i),
    .wr_i   (mem_wr),
    .rd_i   (mem_rd),
    .rdata_o(rdata)
  );

  assign accept    = start && (state_q == S_IDLE);
  assign busy      = (state_q != S_IDLE);
  assign req_entry = '{x: req_i.coord_x, y: req_i.coord_y, z: req_i.coord_z};
  assign pos_addr  = req_i.position[ADDR_W-1:0];
  assign lat_pos   = req_q.position[ADDR_W-1:0];
  assign cnt_addr  = cnt_q[ADDR_W-1:0];

  // Command decode and shift sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    pend_d  = pend_q;
    rsp_d   = rsp_q;
    req_d   = req_q;
    ptr_d   = ptr_q;
    wa_d    = wa_q;
    mem_wr  = '0;
    mem_rd  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d            = req_i;
          pend_d           = 1'b0;
          rsp_d            = '0;
          rsp_d.status     = ST_OK;
          case (req_i.command)
            CMD_APPEND: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_wr = '{en: 1'b1, addr: cnt_addr, data: req_entry};
                cnt_d  = cnt_q + 1'b1;
              end
              done_d = 1'b1;
            end
            CMD_INSERT: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                rsp_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (req_i.position > cnt_q) begin
                rsp_d.status = ST_BADPOS;
                done_d       = 1'b1;
              end else if (req_i.position == cnt_q) begin
                // insert at the end is an append
                mem_wr = '{en: 1'b1, addr: cnt_addr, data: req_entry};
                cnt_d  = cnt_q + 1'b1;
                done_d = 1'b1;
              end else begin
                // shift up, starting from the last entry
                ptr_d   = cnt_addr - 1'b1;
                state_d = S_UP;
              end
            end
            CMD_REMOVE: begin
              if (cnt_q == '0) begin
                rsp_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else if (req_i.position >= cnt_q) begin
                rsp_d.status = ST_BADPOS;
                done_d       = 1'b1;
              end else if (req_i.position == cnt_q - 1'b1) begin
                // removing the last entry needs no move
                cnt_d  = cnt_q - 1'b1;
                done_d = 1'b1;
              end else begin
                // shift down, starting just above the removed entry
                ptr_d   = pos_addr + 1'b1;
                state_d = S_DN;
              end
            end
            CMD_GET: begin
              if (req_i.position >= cnt_q) begin
                rsp_d.status = ST_BADPOS;
                done_d       = 1'b1;
              end else begin
                mem_rd  = '{en: 1'b1, addr: pos_addr};
                state_d = S_GET;
              end
            end
            CMD_SET: begin
              if (req_i.position >= cnt_q) begin
                rsp_d.status = ST_BADPOS;
              end else begin
                mem_wr = '{en: 1'b1, addr: pos_addr, data: req_entry};
              end
              done_d = 1'b1;
            end
            default: begin
              rsp_d.status = ST_BADPOS;
              done_d       = 1'b1;
            end
          endcase
          rsp_d.item_count = cnt_d;
        end
      end

      // read entry ptr, write the previous read one place higher
      S_UP: begin
        mem_rd = '{en: 1'b1, addr: ptr_q};
        if (pend_q) begin
          mem_wr = '{en: 1'b1, addr: wa_q, data: rdata};
        end
        pend_d = 1'b1;
        wa_d   = ptr_q + 1'b1;
        if (ptr_q == lat_pos) begin
          state_d = S_UP_LAST;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end

      S_UP_LAST: begin
        mem_wr  = '{en: 1'b1, addr: wa_q, data: rdata};
        state_d = S_PUT;
      end

      // drop the new entry into the freed slot
      S_PUT: begin
        mem_wr = '{en: 1'b1, addr: lat_pos,
                   data: '{x: req_q.coord_x, y: req_q.coord_y, z: req_q.coord_z}};
        cnt_d            = cnt_q + 1'b1;
        rsp_d.item_count = cnt_d;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end

      // read entry ptr, write the previous read one place lower
      S_DN: begin
        mem_rd = '{en: 1'b1, addr: ptr_q};
        if (pend_q) begin
          mem_wr = '{en: 1'b1, addr: wa_q, data: rdata};
        end
        pend_d = 1'b1;
        wa_d   = ptr_q - 1'b1;
        if (ptr_q == cnt_addr - 1'b1) begin
          state_d = S_DN_LAST;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_DN_LAST: begin
        mem_wr           = '{en: 1'b1, addr: wa_q, data: rdata};
        cnt_d            = cnt_q - 1'b1;
        rsp_d.item_count = cnt_d;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end

      S_GET: begin
        rsp_d.read_x = rdata.x;
        rsp_d.read_y = rdata.y;
        rsp_d.read_z = rdata.z;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    req_q <= req_d;
    ptr_q <= ptr_d;
    wa_q  <= wa_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- design/als_mem.sv -----
// Entry memory of the array list store: one write port, one read port,
// registered read data. Depends on als_pkg.
module als_mem (
  input  logic             clk_i,
  input  als_pkg::mem_wr_t wr_i,
  input  als_pkg::mem_rd_t rd_i,
  output als_pkg::entry_t  rdata_o
);
  import als_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, registered read data, holds its data when idle
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
